[hw/rtl/mbsc_pkg.sv]
package mbsc_pkg;

  localparam int unsigned LANES = 4;

  typedef enum logic [2:0] {
    CFG_BUFFER_LANES  = 3'd0,
    CFG_COMPUTE_LANES = 3'd1,
    CFG_BASE_BIT      = 3'd2,
    CFG_SWEEP_END     = 3'd3,
    CFG_VECTOR_ROWS   = 3'd4,
    CFG_SLICE_LAST    = 3'd5,
    CFG_FETCH_BASE    = 3'd6,
    CFG_MODE_FLAGS    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LANE_MEM      = 2'd0,
    LANE_MAC      = 2'd1,
    LANE_IDLE_MAC = 2'd2
  } lane_mode_e;

  typedef struct packed {
    logic [2:0] buffer_lanes;
    logic [2:0] compute_lanes;
    logic [5:0] base_bit;
  } lane_cfg_t;

  typedef struct packed {
    logic [7:0]        modes;
    logic [27:0]       bit_ids;
    logic signed [7:0] final_id;
  } lane_setup_t;

endpackage

[hw/rtl/mbsc_in_if.sv]
interface mbsc_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic fetch_done;

  modport source (output valid, output start_req, output fetch_done, input ready);
  modport sink (input valid, input start_req, input fetch_done, output ready);
endinterface

[hw/rtl/mbsc_out_if.sv]
interface mbsc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        phase;
  logic [4:0]        strobes;
  logic [3:0]        lane_reads;
  logic [2:0]        acc_slot;
  logic [9:0]        sweep_addr;
  logic [9:0]        mem_row;
  logic [9:0]        row_index;
  logic [15:0]       fetch_addr;
  logic [3:0]        slice_index;
  logic [7:0]        lane_modes;
  logic [27:0]       lane_bit_ids;
  logic signed [7:0] final_bit_id;

  modport source (
    output valid, output phase, output strobes, output lane_reads, output acc_slot,
    output sweep_addr, output mem_row, output row_index, output fetch_addr,
    output slice_index, output lane_modes, output lane_bit_ids, output final_bit_id,
    input ready
  );
  modport sink (
    input valid, input phase, input strobes, input lane_reads, input acc_slot,
    input sweep_addr, input mem_row, input row_index, input fetch_addr,
    input slice_index, input lane_modes, input lane_bit_ids, input final_bit_id,
    output ready
  );
endinterface

[hw/rtl/matrix_bit_slice_controller.sv]
// Bit-sliced matrix engine controller.
// Input channel in_ch carries one clock tick of the engine per transaction: a
// start request and a vector-fetch-done flag. Each input transaction yields
// exactly one transaction on out_ch with the phase, strobes, pointers and the
// latched lane setup after that tick.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, one
// register per cycle, and is sampled only when a start request is taken in
// idle.
// The result is registered and shows on out_ch the cycle after its input is
// taken. One transaction per cycle unless out_ch stalls; the next state and
// result come from one pass of logic between the state and output registers.
// When the receiver stalls, the output register holds its result and in_ch
// stays ready only if that result is taken in the same cycle.
// Reset (rst_ni low) returns the controller to idle, clears all pointers,
// sets cache mode and restores configuration defaults (32-bit accumulators).
module matrix_bit_slice_controller #(
  parameter int unsigned ACC_SLOTS = 8,
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  mbsc_pkg::cfg_idx_e cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  mbsc_in_if.sink           in_ch,
  mbsc_out_if.source        out_ch
);

  localparam int unsigned SLOT_W = (ACC_SLOTS > 1) ? $clog2(ACC_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ACC_SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOT_MOD  = (SLOT_W + 1)'(ACC_SLOTS);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_PRE   = 3'd2,
    PH_ACC   = 3'd3,
    PH_POST  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  logic [2:0]  cfg_buf_q, cfg_comp_q;
  logic        cfg_mode_q;
  logic [5:0]  cfg_base_q;
  logic [9:0]  cfg_end_q, cfg_rows_q;
  logic [3:0]  cfg_last_q;
  logic [15:0] cfg_fetch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_buf_q   <= '0;
      cfg_comp_q  <= '0;
      cfg_base_q  <= '0;
      cfg_end_q   <= '0;
      cfg_rows_q  <= '0;
      cfg_last_q  <= '0;
      cfg_fetch_q <= '0;
      cfg_mode_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mbsc_pkg::CFG_BUFFER_LANES:  cfg_buf_q   <= cfg_data_i[2:0];
        mbsc_pkg::CFG_COMPUTE_LANES: cfg_comp_q  <= cfg_data_i[2:0];
        mbsc_pkg::CFG_BASE_BIT:      cfg_base_q  <= cfg_data_i[5:0];
        mbsc_pkg::CFG_SWEEP_END:     cfg_end_q   <= cfg_data_i[9:0];
        mbsc_pkg::CFG_VECTOR_ROWS:   cfg_rows_q  <= cfg_data_i[9:0];
        mbsc_pkg::CFG_SLICE_LAST:    cfg_last_q  <= cfg_data_i[3:0];
        mbsc_pkg::CFG_FETCH_BASE:    cfg_fetch_q <= cfg_data_i;
        mbsc_pkg::CFG_MODE_FLAGS:    cfg_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mbsc_pkg::lane_cfg_t   lane_cfg;
  mbsc_pkg::lane_setup_t new_setup;

  assign lane_cfg = '{buffer_lanes: cfg_buf_q, compute_lanes: cfg_comp_q,
                      base_bit: cfg_base_q};

  mbsc_lane_setup u_lane_setup (
    .cfg_i   (lane_cfg),
    .setup_o (new_setup)
  );

  phase_e                phase_q, phase_d;
  logic [ADDR_BITS-1:0]  sweep_q, sweep_d, mem_row_q, mem_row_d, lat_end_q, lat_end_d;
  logic [9:0]            row_q, row_d, lat_rows_q, lat_rows_d;
  logic [15:0]           fetch_q, fetch_d;
  logic [3:0]            slice_q, slice_d, lat_last_q, lat_last_d;
  logic [SLOT_W-1:0]     slot_q, slot_d, slot_adv;
  logic [SLOT_W:0]       slot_sum;
  logic                  first_q, first_d, skip_q, skip_d, cache_q, cache_d;
  logic                  mrd_pend_q, mrd_pend_d, acc_pend_q, acc_pend_d;
  logic                  rd_valid, acc32_q, acc32_d;
  mbsc_pkg::lane_setup_t setup_q, setup_d;

  logic                  w_acc, w_mwr, w_mrd, slot_end, last_row;
  logic [3:0]            lane_rd;
  logic [ADDR_BITS+9:0]  sweep_ext, mem_row_ext;
  logic [ADDR_BITS+9:0]  end_ext;
  logic [SLOT_W+2:0]     slot_ext;

  logic                  out_valid_q;
  logic                  in_acc;

  assign end_ext = {{ADDR_BITS{1'b0}}, cfg_end_q};

  always_comb begin
    slot_sum = {1'b0, slot_q} + (acc32_q ? (SLOT_W + 1)'(2) : (SLOT_W + 1)'(1));
    if (slot_sum >= SLOT_MOD) begin
      slot_sum = slot_sum - SLOT_MOD;
    end
    slot_adv = acc_pend_q ? slot_sum[SLOT_W-1:0] : slot_q;
  end

  always_comb begin
    phase_d    = phase_q;
    sweep_d    = sweep_q;
    mem_row_d  = mem_row_q;
    row_d      = row_q;
    fetch_d    = fetch_q;
    slice_d    = slice_q;
    slot_d     = slot_adv;
    first_d    = first_q;
    skip_d     = skip_q;
    cache_d    = cache_q;
    lat_end_d  = lat_end_q;
    lat_rows_d = lat_rows_q;
    lat_last_d = lat_last_q;
    acc32_d    = acc32_q;
    setup_d    = setup_q;
    rd_valid   = mrd_pend_q;
    w_acc      = 1'b0;
    w_mwr      = 1'b0;
    w_mrd      = 1'b0;
    lane_rd    = '0;
    slot_end   = (slot_adv == SLOT_LAST);
    last_row   = (row_q == lat_rows_q);

    case (phase_q)
      PH_WAIT: begin
        if (in_ch.fetch_done) begin
          row_d   = row_q + 10'd1;
          fetch_d = fetch_q + 16'd1;
          phase_d = skip_q ? PH_ACC : PH_PRE;
          skip_d  = 1'b0;
        end
      end
      PH_PRE: begin
        if (!first_q) begin
          w_mrd     = 1'b1;
          mem_row_d = mem_row_q + ADDR_BITS'(1);
        end
        phase_d = PH_ACC;
      end
      PH_ACC: begin
        w_acc = 1'b1;
        for (int i = 0; i < mbsc_pkg::LANES; i++) begin
          lane_rd[i] = (setup_q.modes[2*i +: 2] == mbsc_pkg::LANE_MAC);
        end
        if (slot_end && (sweep_q != '0)) begin
          w_mwr = 1'b1;
          if (!first_q) begin
            w_mrd     = 1'b1;
            mem_row_d = mem_row_q + ADDR_BITS'(1);
          end
        end
        if (sweep_q == lat_end_q) begin
          sweep_d = '0;
          phase_d = PH_POST;
        end else begin
          sweep_d = sweep_q + ADDR_BITS'(1);
        end
      end
      PH_POST: begin
        if (slot_end) begin
          w_mwr = 1'b1;
        end else if (last_row) begin
          w_mwr  = 1'b1;
          slot_d = acc32_q ? SLOT_W'(1) : '0;
          skip_d = 1'b0;
        end else begin
          skip_d = 1'b1;
        end
        phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        phase_d = PH_WAIT;
        if (last_row) begin
          row_d     = '0;
          sweep_d   = '0;
          mem_row_d = '0;
          if (slice_q == lat_last_q) begin
            cache_d = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            slice_d = slice_q + 4'd1;
            first_d = 1'b0;
          end
        end
      end
      PH_IDLE: begin
        if (in_ch.start_req) begin
          lat_end_d  = end_ext[ADDR_BITS-1:0];
          sweep_d    = '0;
          setup_d    = new_setup;
          acc32_d    = cfg_mode_q;
          lat_rows_d = cfg_rows_q;
          lat_last_d = cfg_last_q;
          fetch_d    = cfg_fetch_q;
          cache_d    = 1'b0;
          row_d      = '0;
          slice_d    = '0;
          first_d    = 1'b1;
          slot_d     = cfg_mode_q ? SLOT_W'(1) : '0;
          mem_row_d  = '0;
          phase_d    = PH_WAIT;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    mrd_pend_d = w_mrd;
    acc_pend_d = w_acc;
  end

  assign sweep_ext   = {10'b0, sweep_d};
  assign mem_row_ext = {10'b0, mem_row_d};
  assign slot_ext    = {3'b0, slot_d};

  assign in_ch.ready  = !out_valid_q || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= PH_IDLE;
      sweep_q             <= '0;
      mem_row_q           <= '0;
      row_q               <= '0;
      fetch_q             <= '0;
      slice_q             <= '0;
      slot_q              <= '0;
      first_q             <= 1'b1;
      skip_q              <= 1'b0;
      cache_q             <= 1'b1;
      mrd_pend_q          <= 1'b0;
      acc_pend_q          <= 1'b0;
      lat_end_q           <= '0;
      lat_rows_q          <= '0;
      lat_last_q          <= '0;
      acc32_q             <= 1'b1;
      setup_q             <= '0;
      out_valid_q         <= 1'b0;
      out_ch.phase        <= '0;
      out_ch.strobes      <= '0;
      out_ch.lane_reads   <= '0;
      out_ch.acc_slot     <= '0;
      out_ch.sweep_addr   <= '0;
      out_ch.mem_row      <= '0;
      out_ch.row_index    <= '0;
      out_ch.fetch_addr   <= '0;
      out_ch.slice_index  <= '0;
      out_ch.lane_modes   <= '0;
      out_ch.lane_bit_ids <= '0;
      out_ch.final_bit_id <= '0;
    end else if (in_acc) begin
      phase_q             <= phase_d;
      sweep_q             <= sweep_d;
      mem_row_q           <= mem_row_d;
      row_q               <= row_d;
      fetch_q             <= fetch_d;
      slice_q             <= slice_d;
      slot_q              <= slot_d;
      first_q             <= first_d;
      skip_q              <= skip_d;
      cache_q             <= cache_d;
      mrd_pend_q          <= mrd_pend_d;
      acc_pend_q          <= acc_pend_d;
      lat_end_q           <= lat_end_d;
      lat_rows_q          <= lat_rows_d;
      lat_last_q          <= lat_last_d;
      acc32_q             <= acc32_d;
      setup_q             <= setup_d;
      out_valid_q         <= 1'b1;
      out_ch.phase        <= phase_d;
      out_ch.strobes      <= {cache_d, rd_valid, w_mrd, w_mwr, w_acc};
      out_ch.lane_reads   <= lane_rd;
      out_ch.acc_slot     <= slot_ext[2:0];
      out_ch.sweep_addr   <= sweep_ext[9:0];
      out_ch.mem_row      <= mem_row_ext[9:0];
      out_ch.row_index    <= row_d;
      out_ch.fetch_addr   <= fetch_d;
      out_ch.slice_index  <= slice_d;
      out_ch.lane_modes   <= setup_d.modes;
      out_ch.lane_bit_ids <= setup_d.bit_ids;
      out_ch.final_bit_id <= setup_d.final_id;
    end else if (out_ch.ready) begin
      out_valid_q         <= 1'b0;
    end
  end

endmodule

[hw/rtl/mbsc_lane_setup.sv]
module mbsc_lane_setup (
  input  mbsc_pkg::lane_cfg_t   cfg_i,
  output mbsc_pkg::lane_setup_t setup_o
);

  logic [3:0] work;
  logic [3:0] sum;
  mbsc_pkg::lane_mode_e mode [mbsc_pkg::LANES];

  assign sum  = {1'b0, cfg_i.buffer_lanes} + {1'b0, cfg_i.compute_lanes};
  assign work = (sum == 4'd0) ? 4'd4 : sum;

  always_comb begin
    mode[0] = mbsc_pkg::LANE_MEM;
    mode[1] = (cfg_i.buffer_lanes > 3'd1) ? mbsc_pkg::LANE_MEM : mbsc_pkg::LANE_MAC;
    if (cfg_i.buffer_lanes > 3'd2) begin
      mode[2] = mbsc_pkg::LANE_MEM;
    end else if (work <= 4'd2) begin
      mode[2] = mbsc_pkg::LANE_IDLE_MAC;
    end else begin
      mode[2] = mbsc_pkg::LANE_MAC;
    end
    mode[3] = (work <= 4'd3) ? mbsc_pkg::LANE_IDLE_MAC : mbsc_pkg::LANE_MAC;
  end

  always_comb begin
    setup_o.modes   = '0;
    setup_o.bit_ids = '0;
    for (int i = 0; i < mbsc_pkg::LANES; i++) begin
      setup_o.modes[2*i +: 2] = mode[i];
      if (3'(i) >= cfg_i.buffer_lanes) begin
        setup_o.bit_ids[7*i +: 7] = {1'b0, cfg_i.base_bit} + 7'(i)
                                    - {4'b0, cfg_i.buffer_lanes};
      end
    end
    setup_o.final_id = $signed({2'b0, cfg_i.base_bit} + {5'b0, cfg_i.compute_lanes} - 8'd1);
  end

endmodule

[hw/rtl/mbsc_checker.sv]
module mbsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] phase_i,
  input logic [4:0] strobes_i,
  input logic [3:0] lane_reads_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("input transaction without result");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken over a pending result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (phase_i == 3'd0) |->
      (strobes_i[2:0] == 3'b000) && (lane_reads_i == 4'd0) && strobes_i[4])
    else $error("strobes active in idle");

  a_acc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((lane_reads_i != 4'd0) || strobes_i[0]) |->
      strobes_i[0] && ((phase_i == 3'd3) || (phase_i == 3'd4)))
    else $error("accumulate strobe outside sweep");

endmodule

bind matrix_bit_slice_controller mbsc_checker u_mbsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .phase_i      (out_ch.phase),
  .strobes_i    (out_ch.strobes),
  .lane_reads_i (out_ch.lane_reads)
);

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ACC_SLOTS = 8;
  localparam int LONG_HOLD = 300;
  localparam int TICK_CAP  = 28;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_PRE   = 3'd2,
    PH_ACC   = 3'd3,
    PH_POST  = 3'd4,
    PH_CHECK = 3'd5
  } ctrl_phase_e;

  localparam int STB_ACC_WR  = 0;
  localparam int STB_MEM_WR  = 1;
  localparam int STB_MEM_RD  = 2;
  localparam int STB_RD_VAL  = 3;
  localparam int STB_CACHE   = 4;

  typedef struct packed {
    logic [2:0]        phase;
    logic [4:0]        strobes;
    logic [3:0]        lane_reads;
    logic [2:0]        acc_slot;
    logic [9:0]        sweep_addr;
    logic [9:0]        mem_row;
    logic [9:0]        row_index;
    logic [15:0]       fetch_addr;
    logic [3:0]        slice_index;
    logic [7:0]        lane_modes;
    logic [27:0]       lane_bit_ids;
    logic signed [7:0] final_bit_id;
  } tick_outputs_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  mbsc_pkg::cfg_idx_e cfg_idx_i;
  logic [15:0]        cfg_data_i;

  mbsc_in_if  in_ch ();
  mbsc_out_if out_ch ();

  matrix_bit_slice_controller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // register copies
  logic [2:0]  reg_buf_lanes;
  logic [2:0]  reg_mac_lanes;
  logic [5:0]  reg_base_bit;
  logic [9:0]  reg_sweep_end;
  logic [9:0]  reg_vec_rows;
  logic [3:0]  reg_slice_last;
  logic [15:0] reg_fetch_base;
  logic [2:0]  reg_mode_flags;

  // controller copy
  logic [2:0]  fsm_phase;
  logic [9:0]  sweep_ptr;
  logic [9:0]  mem_row_ptr;
  logic [9:0]  row_ptr;
  logic [15:0] fetch_ptr;
  logic [3:0]  slice_ptr;
  int          slot_ptr;
  logic        first_slice;
  logic        skip_mem_read;
  logic        cache_mode;
  logic        mem_read_pending;
  logic        acc_write_pending;
  logic        read_valid;

  logic                 [9:0] cmd_end;
  logic                 [9:0] cmd_rows;
  logic                 [3:0] cmd_last;
  logic                       cmd_acc32;
  mbsc_pkg::lane_mode_e       cmd_mode [mbsc_pkg::LANES];
  logic                 [6:0] cmd_bit [mbsc_pkg::LANES];
  logic                 [7:0] cmd_final;

  tick_outputs_t pending_tick_outputs [$];
  int            mismatches;
  int            tx_idle_pct;
  int            rx_idle_pct;
  bit            hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("FAIL matrix_bit_slice_controller");
    $finish;
  end

  task automatic reset_shadow();
    reg_buf_lanes  = '0;
    reg_mac_lanes  = '0;
    reg_base_bit   = '0;
    reg_sweep_end  = '0;
    reg_vec_rows   = '0;
    reg_slice_last = '0;
    reg_fetch_base = '0;
    reg_mode_flags = 3'd1;
    fsm_phase         = PH_IDLE;
    sweep_ptr         = '0;
    mem_row_ptr       = '0;
    row_ptr           = '0;
    fetch_ptr         = '0;
    slice_ptr         = '0;
    slot_ptr          = 0;
    first_slice       = 1'b1;
    skip_mem_read     = 1'b0;
    cache_mode        = 1'b1;
    mem_read_pending  = 1'b0;
    acc_write_pending = 1'b0;
    read_valid        = 1'b0;
    cmd_end   = '0;
    cmd_rows  = '0;
    cmd_last  = '0;
    cmd_acc32 = 1'b1;
    for (int i = 0; i < mbsc_pkg::LANES; i++) begin
      cmd_mode[i] = mbsc_pkg::LANE_MEM;
      cmd_bit[i]  = '0;
    end
    cmd_final = '0;
  endtask

  task automatic compute_tick_outputs(input logic start, input logic fdone,
                                      output tick_outputs_t r);
    logic       w_acc;
    logic       w_mwr;
    logic       w_mrd;
    logic       slot_end;
    logic       last_row;
    logic [3:0] lane_rd;
    logic [2:0] nxt;
    int         nb;
    int         nc;
    int         work;
    int         tmp;
    w_acc   = 1'b0;
    w_mwr   = 1'b0;
    w_mrd   = 1'b0;
    lane_rd = '0;
    nxt     = fsm_phase;

    read_valid = mem_read_pending;
    if (acc_write_pending) slot_ptr = (slot_ptr + (cmd_acc32 ? 2 : 1)) % ACC_SLOTS;
    slot_end = (slot_ptr == ACC_SLOTS - 1);
    last_row = (row_ptr == cmd_rows);

    case (fsm_phase)
      PH_WAIT: begin
        if (fdone) begin
          row_ptr       = row_ptr + 10'd1;
          fetch_ptr     = fetch_ptr + 16'd1;
          nxt           = skip_mem_read ? PH_ACC : PH_PRE;
          skip_mem_read = 1'b0;
        end
      end
      PH_PRE: begin
        if (!first_slice) begin
          w_mrd       = 1'b1;
          mem_row_ptr = mem_row_ptr + 10'd1;
        end
        nxt = PH_ACC;
      end
      PH_ACC: begin
        w_acc = 1'b1;
        for (int i = 0; i < mbsc_pkg::LANES; i++) begin
          if (cmd_mode[i] == mbsc_pkg::LANE_MAC) lane_rd[i] = 1'b1;
        end
        if (slot_end && sweep_ptr != 10'd0) begin
          w_mwr = 1'b1;
          if (!first_slice) begin
            w_mrd       = 1'b1;
            mem_row_ptr = mem_row_ptr + 10'd1;
          end
        end
        if (sweep_ptr == cmd_end) begin
          sweep_ptr = '0;
          nxt       = PH_POST;
        end else begin
          sweep_ptr = sweep_ptr + 10'd1;
        end
      end
      PH_POST: begin
        if (slot_end) begin
          w_mwr = 1'b1;
        end else if (last_row) begin
          w_mwr         = 1'b1;
          slot_ptr      = cmd_acc32 ? 1 : 0;
          skip_mem_read = 1'b0;
        end else begin
          skip_mem_read = 1'b1;
        end
        nxt = PH_CHECK;
      end
      PH_CHECK: begin
        nxt = PH_WAIT;
        if (last_row) begin
          row_ptr     = '0;
          sweep_ptr   = '0;
          mem_row_ptr = '0;
          if (slice_ptr == cmd_last) begin
            cache_mode = 1'b1;
            nxt        = PH_IDLE;
          end else begin
            slice_ptr   = slice_ptr + 4'd1;
            first_slice = 1'b0;
          end
        end
      end
      default: begin
        nxt = PH_IDLE;
        if (fsm_phase == PH_IDLE && start) begin
          nb        = int'(reg_buf_lanes);
          nc        = int'(reg_mac_lanes);
          cmd_end   = reg_sweep_end;
          sweep_ptr = '0;
          for (int i = 0; i < mbsc_pkg::LANES; i++) begin
            tmp        = (i < nb) ? 0 : int'(reg_base_bit) + i - nb;
            cmd_bit[i] = tmp[6:0];
          end
          tmp       = int'(reg_base_bit) + nc - 1;
          cmd_final = tmp[7:0];
          work      = (nb + nc == 0) ? 4 : nb + nc;
          cmd_mode[0] = mbsc_pkg::LANE_MEM;
          cmd_mode[1] = (nb > 1) ? mbsc_pkg::LANE_MEM : mbsc_pkg::LANE_MAC;
          if (nb > 2) cmd_mode[2] = mbsc_pkg::LANE_MEM;
          else if (work <= 2) cmd_mode[2] = mbsc_pkg::LANE_IDLE_MAC;
          else cmd_mode[2] = mbsc_pkg::LANE_MAC;
          cmd_mode[3] = (work <= 3) ? mbsc_pkg::LANE_IDLE_MAC : mbsc_pkg::LANE_MAC;
          cmd_acc32   = reg_mode_flags[0];
          cmd_rows    = reg_vec_rows;
          cmd_last    = reg_slice_last;
          fetch_ptr   = reg_fetch_base;
          cache_mode  = 1'b0;
          row_ptr     = '0;
          slice_ptr   = '0;
          first_slice = 1'b1;
          slot_ptr    = cmd_acc32 ? 1 : 0;
          mem_row_ptr = '0;
          nxt         = PH_WAIT;
        end
      end
    endcase

    mem_read_pending  = w_mrd;
    acc_write_pending = w_acc;
    fsm_phase         = nxt;

    r = '0;
    r.phase                = fsm_phase;
    r.strobes[STB_ACC_WR]  = w_acc;
    r.strobes[STB_MEM_WR]  = w_mwr;
    r.strobes[STB_MEM_RD]  = w_mrd;
    r.strobes[STB_RD_VAL]  = read_valid;
    r.strobes[STB_CACHE]   = cache_mode;
    r.lane_reads           = lane_rd;
    r.acc_slot             = slot_ptr[2:0];
    r.sweep_addr           = sweep_ptr;
    r.mem_row              = mem_row_ptr;
    r.row_index            = row_ptr;
    r.fetch_addr           = fetch_ptr;
    r.slice_index          = slice_ptr;
    for (int i = 0; i < mbsc_pkg::LANES; i++) begin
      r.lane_modes[2*i +: 2]   = cmd_mode[i];
      r.lane_bit_ids[7*i +: 7] = cmd_bit[i];
    end
    r.final_bit_id = cmd_final;
  endtask

  function automatic string fmt_tick(input tick_outputs_t t);
    return $sformatf({"ph=%0d stb=%b lrd=%b slot=%0d sw=%0d mrow=%0d row=%0d ",
                      "fetch=%h slice=%0d modes=%h bits=%h final=%0d"},
                     t.phase, t.strobes, t.lane_reads, t.acc_slot, t.sweep_addr,
                     t.mem_row, t.row_index, t.fetch_addr, t.slice_index,
                     t.lane_modes, t.lane_bit_ids, t.final_bit_id);
  endfunction

  always @(posedge clk_i) begin
    tick_outputs_t got;
    tick_outputs_t want;
    string         bad;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.phase, out_ch.strobes, out_ch.lane_reads, out_ch.acc_slot,
               out_ch.sweep_addr, out_ch.mem_row, out_ch.row_index, out_ch.fetch_addr,
               out_ch.slice_index, out_ch.lane_modes, out_ch.lane_bit_ids,
               out_ch.final_bit_id};
        if (pending_tick_outputs.size() == 0) begin
          if (mismatches < 10) $display("unexpected transaction: %s", fmt_tick(got));
          mismatches++;
        end else begin
          want = pending_tick_outputs.pop_front();
          bad  = "";
          if (got.phase !== want.phase) bad = {bad, " phase"};
          if (got.strobes !== want.strobes) bad = {bad, " strobes"};
          if (got.lane_reads !== want.lane_reads) bad = {bad, " lane_reads"};
          if (got.acc_slot !== want.acc_slot) bad = {bad, " acc_slot"};
          if (got.sweep_addr !== want.sweep_addr) bad = {bad, " sweep_addr"};
          if (got.mem_row !== want.mem_row) bad = {bad, " mem_row"};
          if (got.row_index !== want.row_index) bad = {bad, " row_index"};
          if (got.fetch_addr !== want.fetch_addr) bad = {bad, " fetch_addr"};
          if (got.slice_index !== want.slice_index) bad = {bad, " slice_index"};
          if (got.lane_modes !== want.lane_modes) bad = {bad, " lane_modes"};
          if (got.lane_bit_ids !== want.lane_bit_ids) bad = {bad, " lane_bit_ids"};
          if (got.final_bit_id !== want.final_bit_id) bad = {bad, " final_bit_id"};
          if (bad != "") begin
            if (mismatches < 10) begin
              $display("mismatch at %0t on%s", $realtime, bad);
              $display("  expected %s", fmt_tick(want));
              $display("  actual   %s", fmt_tick(got));
            end
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mbsc_pkg::CFG_BUFFER_LANES:  reg_buf_lanes  = cfg_data_i[2:0];
          mbsc_pkg::CFG_COMPUTE_LANES: reg_mac_lanes  = cfg_data_i[2:0];
          mbsc_pkg::CFG_BASE_BIT:      reg_base_bit   = cfg_data_i[5:0];
          mbsc_pkg::CFG_SWEEP_END:     reg_sweep_end  = cfg_data_i[9:0];
          mbsc_pkg::CFG_VECTOR_ROWS:   reg_vec_rows   = cfg_data_i[9:0];
          mbsc_pkg::CFG_SLICE_LAST:    reg_slice_last = cfg_data_i[3:0];
          mbsc_pkg::CFG_FETCH_BASE:    reg_fetch_base = cfg_data_i;
          mbsc_pkg::CFG_MODE_FLAGS:    reg_mode_flags = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        compute_tick_outputs(in_ch.start_req, in_ch.fetch_done, want);
        pending_tick_outputs = {pending_tick_outputs, want};
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic start, input logic fdone);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.start_req  <= start;
    in_ch.fetch_done <= fdone;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_tick_outputs.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input mbsc_pkg::cfg_idx_e idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic write_setup(input int nb, input int nc, input int base, input int last_addr,
                             input int rows, input int last_slice, input int fbase,
                             input int flags);
    drain();
    cfg_write(mbsc_pkg::CFG_BUFFER_LANES, 16'(nb));
    cfg_write(mbsc_pkg::CFG_COMPUTE_LANES, 16'(nc));
    cfg_write(mbsc_pkg::CFG_BASE_BIT, 16'(base));
    cfg_write(mbsc_pkg::CFG_SWEEP_END, 16'(last_addr));
    cfg_write(mbsc_pkg::CFG_VECTOR_ROWS, 16'(rows));
    cfg_write(mbsc_pkg::CFG_SLICE_LAST, 16'(last_slice));
    cfg_write(mbsc_pkg::CFG_FETCH_BASE, 16'(fbase));
    cfg_write(mbsc_pkg::CFG_MODE_FLAGS, 16'(flags));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int tick_budget(input int rows, input int last_addr, input int last_slice);
    int n;
    n = ((rows == 0) ? 1024 : rows) * (last_addr + 8) * (last_slice + 1) + 10;
    return (n > TICK_CAP) ? TICK_CAP : n;
  endfunction

  task automatic run_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      send_tick($urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
    end
  endtask

  task automatic test_directed();
    logic [1:0] seq [$];
    write_setup(1, 2, 5, 2, 1, 1, 16'hFFFE, 0);
    seq = '{2'b01, 2'b10, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00,
            2'b01, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b01, 2'b10, 2'b01};
    foreach (seq[i]) send_tick(seq[i][1], seq[i][0]);
    // rewrite while mid-command: must not disturb the running command
    write_setup(0, 0, 0, 0, 2, 0, 0, 1);
    repeat (8) send_tick(1'b1, 1'b1);
  endtask

  task automatic test_random_setups(input int count);
    int nb;
    int nc;
    int last_addr;
    int rows;
    int last_slice;
    for (int k = 0; k < count; k++) begin
      nb         = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      nc         = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      last_addr  = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      rows       = $urandom_range(1, 2);
      last_slice = $urandom_range(0, 1);
      write_setup(nb, nc, $urandom_range(0, 63), last_addr, rows, last_slice,
                  $urandom_range(0, 65535), $urandom_range(0, 7));
      run_ticks(tick_budget(rows, last_addr, last_slice));
    end
  endtask

  task automatic test_backpressure();
    write_setup(2, 2, 17, 5, 2, 1, 16'h1234, 0);
    hold_off_req = 1'b1;
    run_ticks(40);
  endtask

  task automatic test_extremes();
    write_setup(0, 0, 0, 0, 1023, 0, 16'hFFFF, 1);
    run_ticks(tick_budget(1023, 0, 0));
    write_setup(7, 7, 63, 1023, 1, 0, 16'hFFF0, 0);
    run_ticks(tick_budget(1, 1023, 0));
    write_setup(0, 4, 63, 1, 2, 15, 16'h8000, 7);
    run_ticks(tick_budget(2, 1, 15));
    write_setup(4, 4, 0, 0, 0, 0, 0, 6);
    run_ticks(tick_budget(0, 0, 0));
    write_setup(2, 0, 31, 3, 1, 0, 16'h0001, 3);
    run_ticks(tick_budget(1, 3, 0));
  endtask

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= mbsc_pkg::CFG_BUFFER_LANES;
    cfg_data_i       <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.start_req  <= 1'b0;
    in_ch.fetch_done <= 1'b0;
    mismatches   = 0;
    hold_off_req = 1'b0;
    tx_idle_pct  = 36;
    rx_idle_pct  = 58;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_setups(3);
    test_backpressure();

    tx_idle_pct = 58;
    rx_idle_pct = 36;
    test_random_setups(3);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_setups(3);
    test_extremes();

    drain();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && pending_tick_outputs.size() == 0) begin
      $display("PASS matrix_bit_slice_controller");
    end else begin
      $display("FAIL matrix_bit_slice_controller");
    end
    $finish;
  end

endmodule
